>>> rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash - shared package
// Word type, initial hash values, round functions and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sha1_pkg;

   typedef logic [31:0] word_type;

   localparam word_type IV_H0 = 32'h6745_2301;
   localparam word_type IV_H1 = 32'hEFCD_AB89;
   localparam word_type IV_H2 = 32'h98BA_DCFE;
   localparam word_type IV_H3 = 32'h1032_5476;
   localparam word_type IV_H4 = 32'hC3D2_E1F0;

   localparam word_type K_R0 = 32'h5A82_7999;
   localparam word_type K_R1 = 32'h6ED9_EBA1;
   localparam word_type K_R2 = 32'h8F1B_BCDC;
   localparam word_type K_R3 = 32'hCA62_C1D6;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam int         ROUNDS    = 80;
   localparam int         DIGEST_WORDS = 5;

   // byte source for the schedule packer
   localparam logic [1:0] BSEL_MSG  = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   typedef struct packed {
      logic       put_byte;
      logic [1:0] byte_sel;
      logic       count_byte;
      logic       load_work;
      logic       round_en;
      logic [6:0] rnd;
      logic       add_chain;
      logic       init_hash;
      logic [2:0] word_sel;
   } cmd_type;

   typedef struct packed {
      logic [5:0] pos;
   } sts_type;

   function automatic word_type round_k(input logic [6:0] rnd);
      word_type k;
      if (rnd < 7'd20) begin
         k = K_R0;
      end else if (rnd < 7'd40) begin
         k = K_R1;
      end else if (rnd < 7'd60) begin
         k = K_R2;
      end else begin
         k = K_R3;
      end
      return k;
   endfunction

   function automatic word_type round_f(input logic [6:0] rnd, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

>>> rtl/sha1_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Byte packer into a 16-word schedule window, round logic on the working
// registers, chaining values and the 64-bit message byte count.
// ----------------------------------------------------------------------------
module sha1_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        data_byte,
   input  sha1_pkg::cmd_type cmd,
   output sha1_pkg::sts_type sts,
   output logic [31:0]       digest_word
);
   import sha1_pkg::*;

   word_type   win_ff [16];
   word_type   win_in [16];
   word_type   work_ff [5];
   word_type   work_in [5];
   word_type   hash_ff [5];
   word_type   hash_in [5];
   logic [23:0] acc_ff, acc_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] count_ff, count_in;

   logic [7:0]  byte_val;
   logic [63:0] bit_len;
   word_type    packed_word;
   word_type    sched_w;
   word_type    temp;

   assign bit_len     = {count_ff[60:0], 3'b000};
   assign packed_word = {acc_ff, byte_val};
   assign sts.pos     = pos_ff;

   always_comb begin
      case (cmd.byte_sel)
         BSEL_MSG:  byte_val = data_byte;
         BSEL_PAD:  byte_val = PAD_BYTE;
         BSEL_LEN:  byte_val = bit_len[8 * (7 - int'(pos_ff[2:0])) +: 8];
         default:   byte_val = 8'h00;
      endcase
   end

   // first sixteen rounds recirculate the loaded words, later ones expand
   always_comb begin
      if (cmd.rnd < 7'd16) begin
         sched_w = win_ff[0];
      end else begin
         sched_w = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
         sched_w = {sched_w[30:0], sched_w[31]};
      end
      temp = {work_ff[0][26:0], work_ff[0][31:27]} +
             round_f(cmd.rnd, work_ff[1], work_ff[2], work_ff[3]) +
             work_ff[4] + round_k(cmd.rnd) + sched_w;
   end

   always_comb begin
      win_in   = win_ff;
      work_in  = work_ff;
      hash_in  = hash_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      count_in = count_ff;

      if (cmd.put_byte) begin
         acc_in = packed_word[23:0];
         pos_in = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = packed_word;
         end
      end
      if (cmd.count_byte) begin
         count_in = count_ff + 64'd1;
      end
      if (cmd.load_work) begin
         work_in = hash_ff;
      end
      if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = sched_w;
         work_in[4] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[1] = work_ff[0];
         work_in[0] = temp;
      end
      if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (cmd.init_hash) begin
         hash_in[0] = IV_H0;
         hash_in[1] = IV_H1;
         hash_in[2] = IV_H2;
         hash_in[3] = IV_H3;
         hash_in[4] = IV_H4;
         count_in   = '0;
         pos_in     = '0;
      end
   end

   always_comb begin
      case (cmd.word_sel)
         3'd0:    digest_word = hash_ff[0];
         3'd1:    digest_word = hash_ff[1];
         3'd2:    digest_word = hash_ff[2];
         3'd3:    digest_word = hash_ff[3];
         3'd4:    digest_word = hash_ff[4];
         default: digest_word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
      acc_ff  <= acc_in;
      if (reset) begin
         hash_ff[0] <= IV_H0;
         hash_ff[1] <= IV_H1;
         hash_ff[2] <= IV_H2;
         hash_ff[3] <= IV_H3;
         hash_ff[4] <= IV_H4;
         pos_ff     <= '0;
         count_ff   <= '0;
      end else begin
         hash_ff  <= hash_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 compression rounds and the
// five-word digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              byte_valid,
   input  logic              msg_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_last,
   output sha1_pkg::cmd_type cmd,
   input  sha1_pkg::sts_type sts
);
   import sha1_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_PAD   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam logic [6:0] LAST_RND  = 7'(ROUNDS - 1);
   localparam logic [2:0] LAST_WORD = 3'(DIGEST_WORDS - 1);

   logic [2:0] state_ff, state_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] word_ff, word_in;
   logic       pend_end_ff, pend_end_in;
   logic       first_ff, first_in;     // 0x80 still to be written
   logic       len_ok_ff, len_ok_in;   // this block carries the length
   logic       last_blk_ff, last_blk_in;

   always_comb begin
      state_in    = state_ff;
      rnd_in      = rnd_ff;
      word_in     = word_ff;
      pend_end_in = pend_end_ff;
      first_in    = first_ff;
      len_ok_in   = len_ok_ff;
      last_blk_in = last_blk_ff;
      cmd          = '0;
      cmd.rnd      = rnd_ff;
      cmd.word_sel = word_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_last     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pend_end_in = msg_end;
               first_in    = 1'b1;
               len_ok_in   = 1'b0;
               last_blk_in = 1'b0;
               if (byte_valid) begin
                  cmd.put_byte   = 1'b1;
                  cmd.byte_sel   = BSEL_MSG;
                  cmd.count_byte = 1'b1;
               end
               if (byte_valid && sts.pos == 6'd63) begin
                  state_in = S_LOAD;
               end else if (msg_end) begin
                  state_in = S_PAD;
               end
            end
         end
         S_LOAD: begin
            cmd.load_work = 1'b1;
            rnd_in        = '0;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (rnd_ff == LAST_RND) begin
               rnd_in   = '0;
               state_in = S_ADD;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end
         S_ADD: begin
            cmd.add_chain = 1'b1;
            if (last_blk_ff) begin
               word_in  = '0;
               state_in = S_EMIT;
            end else if (pend_end_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            cmd.put_byte = 1'b1;
            if (first_ff) begin
               cmd.byte_sel = BSEL_PAD;
            end else if (len_ok_ff && sts.pos >= 6'd56) begin
               cmd.byte_sel = BSEL_LEN;
            end else begin
               cmd.byte_sel = BSEL_ZERO;
            end
            first_in = 1'b0;
            // length fits behind the marker only when it lands below byte 56
            if (first_ff && sts.pos <= 6'd55) begin
               len_ok_in = 1'b1;
            end
            if (sts.pos == 6'd63) begin
               last_blk_in = len_ok_ff;
               len_ok_in   = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (word_ff == LAST_WORD);
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  cmd.init_hash = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rnd_ff      <= '0;
         word_ff     <= '0;
         pend_end_ff <= 1'b0;
         first_ff    <= 1'b0;
         len_ok_ff   <= 1'b0;
         last_blk_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rnd_ff      <= rnd_in;
         word_ff     <= word_in;
         pend_end_ff <= pend_end_in;
         first_ff    <= first_in;
         len_ok_ff   <= len_ok_in;
         last_blk_ff <= last_blk_in;
      end
   end

endmodule

>>> rtl/sha1_byte_stream_hash.sv
// Intake: a byte item is taken while req_tready is high; the byte that fills a
// 64-byte block runs the load, 80 rounds and chaining add before the next item is taken.
// Message end: one padding byte per cycle (up to 72 over two blocks), the same load,
// rounds and add per padded block, then five digest items, one per cycle while rsp_tready is high.
// Intake stays closed while a full 64-byte block is hashed.
// Reset is synchronous: control clears, chaining values load the SHA-1 IV.
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash - top level
// Takes message bytes one item at a time and returns the five digest words
// of each message after its end marker.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast    // word_last
);
   import sha1_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sha1_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .byte_valid (req_tuser),
      .msg_end    (req_tlast),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_last   (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_tdata),
      .cmd         (cmd),
      .sts         (sts),
      .digest_word (rsp_tdata)
   );

   // intake and digest output never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("intake open while digest pending");

   // the final digest item hands straight back to intake
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("intake not reopened after digest");

   // an empty item leaves the block ready for the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser && !req_tlast) |=> req_tready)
      else $error("empty item stalled intake");

   // digest output only starts at a word boundary with the byte position cleared
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (sts.pos == 6'd0) && !rsp_tlast)
      else $error("digest started mid block");

endmodule
